/* hdl/assert_macros.svh */
// Assertion macros shared by the block's RTL.
// Defining NO_ASSERTIONS compiles every use to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset.
`define OWBM_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// Check that a condition implies another at the same edge.
`define OWBM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`else

`define OWBM_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define OWBM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/owbm_pkg.sv */
`timescale 1ns / 1ps

package owbm_pkg;

    // Field and register widths
    localparam int ActionW  = 2;
    localparam int ByteW    = 8;
    localparam int TimerW   = 10;
    localparam int CountW   = 3;
    localparam int CfgNum   = 8;
    localparam int CfgIdxW  = $clog2(CfgNum);
    localparam int CfgDataW = 10;

    // Presence sampling: sample count and spacing in ticks
    localparam logic [CountW-1:0] PresenceSamples = CountW'(7);
    localparam logic [TimerW-1:0] SampleSpacing   = TimerW'(10);

    // Command codes on the action field
    typedef enum logic [ActionW-1:0] {
        ACT_TICK  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_RESET_LOW      = 3'd0,
        CFG_PRESENCE_DELAY = 3'd1,
        CFG_PRESENCE_MAX   = 3'd2,
        CFG_WRITE_LOW      = 3'd3,
        CFG_WRITE_HOLD     = 3'd4,
        CFG_READ_LOW       = 3'd5,
        CFG_READ_SAMPLE    = 3'd6,
        CFG_READ_RECOVER   = 3'd7
    } t_cfg_idx;

    // Configuration register values after reset
    localparam logic [9:0] ResetLowDef     = 10'd500;
    localparam logic [7:0] PresenceDelayDef = 8'd60;
    localparam logic [2:0] PresenceMaxDef  = 3'd3;
    localparam logic [7:0] WriteLowDef     = 8'd5;
    localparam logic [7:0] WriteHoldDef    = 8'd40;
    localparam logic [7:0] ReadLowDef      = 8'd7;
    localparam logic [7:0] ReadSampleDef   = 8'd5;
    localparam logic [7:0] ReadRecoverDef  = 8'd45;

    // Timing settings handed from the register file to the sequencer
    typedef struct packed {
        logic [9:0] reset_low;
        logic [7:0] presence_delay;
        logic [2:0] presence_max;
        logic [7:0] write_low;
        logic [7:0] write_hold;
        logic [7:0] read_low;
        logic [7:0] read_sample;
        logic [7:0] read_recover;
    } t_cfg;

endpackage

/* hdl/owbm_cmd_if.sv */
`timescale 1ns / 1ps

interface owbm_cmd_if
    import owbm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ActionW-1:0] action;
    logic [ByteW-1:0]   data_byte;
    logic              line_in;

    modport source (output valid, output action, output data_byte, output line_in,
                    input ready);
    modport sink   (input valid, input action, input data_byte, input line_in,
                    output ready);
endinterface

/* hdl/owbm_res_if.sv */
`timescale 1ns / 1ps

interface owbm_res_if
    import owbm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    logic             presence_ok;
    logic [ByteW-1:0] read_byte;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence_ok, output read_byte, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence_ok, input read_byte, output ready);
endinterface

/* hdl/owbm_cfg_regs.sv */
`timescale 1ns / 1ps

module owbm_cfg_regs
    import owbm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    // Load defaults at reset, take one register per write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low      <= ResetLowDef;
            r_cfg.presence_delay <= PresenceDelayDef;
            r_cfg.presence_max   <= PresenceMaxDef;
            r_cfg.write_low      <= WriteLowDef;
            r_cfg.write_hold     <= WriteHoldDef;
            r_cfg.read_low       <= ReadLowDef;
            r_cfg.read_sample    <= ReadSampleDef;
            r_cfg.read_recover   <= ReadRecoverDef;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RESET_LOW:      r_cfg.reset_low      <= i_cfg_data[9:0];
                CFG_PRESENCE_DELAY: r_cfg.presence_delay <= i_cfg_data[7:0];
                CFG_PRESENCE_MAX:   r_cfg.presence_max   <= i_cfg_data[2:0];
                CFG_WRITE_LOW:      r_cfg.write_low      <= i_cfg_data[7:0];
                CFG_WRITE_HOLD:     r_cfg.write_hold     <= i_cfg_data[7:0];
                CFG_READ_LOW:       r_cfg.read_low       <= i_cfg_data[7:0];
                CFG_READ_SAMPLE:    r_cfg.read_sample    <= i_cfg_data[7:0];
                CFG_READ_RECOVER:   r_cfg.read_recover   <= i_cfg_data[7:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/owbm_seq.sv */
`timescale 1ns / 1ps

module owbm_seq
    import owbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    owbm_cmd_if.sink   i_cmd,
    owbm_res_if.source o_res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_REL, PH_RST_SAMP, PH_RST_HIGH,
        PH_WR_LOW, PH_WR_HOLD, PH_RD_LOW, PH_RD_REL, PH_RD_REC
    } t_phase;

    // Input register
    logic               r_in_valid;
    logic [ActionW-1:0] r_action;
    logic [ByteW-1:0]   r_data;
    logic               r_line;

    // Sequencer state
    t_phase             r_phase, n_phase;
    logic [TimerW-1:0]  r_timer, n_timer;
    logic [CountW-1:0]  r_bit, n_bit;
    logic [ByteW-1:0]   r_shift, n_shift;
    logic [CountW-1:0]  r_high_cnt, n_high_cnt;
    logic [CountW-1:0]  r_samp_idx, n_samp_idx;
    logic               r_presence, n_presence;
    logic [ByteW-1:0]   r_last_read, n_last_read;

    // Result register
    logic               r_out_valid;
    logic               r_drive;
    logic               r_busy;
    logic               r_done;
    logic               n_drive;
    logic               n_done;

    logic               adv;
    logic               fire;
    logic [TimerW-1:0]  dur;
    logic [TimerW-1:0]  t_inc;
    logic               t_end;

    // The item in the input register moves on when the result slot is free
    assign adv         = !r_out_valid || o_res.ready;
    assign fire        = r_in_valid && adv;
    assign i_cmd.ready = !r_in_valid || adv;

    // Pick the length of the current phase
    always_comb begin
        case (r_phase)
            PH_RST_LOW:  dur = i_cfg.reset_low;
            PH_RST_REL:  dur = TimerW'(i_cfg.presence_delay);
            PH_RST_SAMP: dur = SampleSpacing;
            PH_WR_LOW:   dur = TimerW'(i_cfg.write_low);
            PH_WR_HOLD:  dur = TimerW'(i_cfg.write_hold);
            PH_RD_LOW:   dur = TimerW'(i_cfg.read_low);
            PH_RD_REL:   dur = TimerW'(i_cfg.read_sample);
            PH_RD_REC:   dur = TimerW'(i_cfg.read_recover);
            default:     dur = '0;
        endcase
    end

    // A zero length counts as one tick
    assign t_inc = r_timer + TimerW'(1);
    assign t_end = (dur == '0) || (t_inc >= dur);

    // Next state for one item
    always_comb begin
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_high_cnt  = r_high_cnt;
        n_samp_idx  = r_samp_idx;
        n_presence  = r_presence;
        n_last_read = r_last_read;
        n_done      = 1'b0;

        if (t_action'(r_action) != ACT_TICK) begin
            // Start an operation only from idle; drop the command otherwise
            if (r_phase == PH_IDLE) begin
                n_timer = '0;
                case (t_action'(r_action))
                    ACT_RESET: begin
                        n_high_cnt = '0;
                        n_samp_idx = '0;
                        n_phase    = PH_RST_LOW;
                    end
                    ACT_WRITE: begin
                        n_bit   = '0;
                        n_shift = r_data;
                        n_phase = PH_WR_LOW;
                    end
                    default: begin
                        n_bit   = '0;
                        n_shift = '0;
                        n_phase = PH_RD_LOW;
                    end
                endcase
            end
        end else begin
            // Advance the slot timer on a tick
            if (r_phase != PH_IDLE && r_phase != PH_RST_HIGH) begin
                n_timer = t_end ? '0 : t_inc;
            end
            case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_RST_LOW: begin
                    if (t_end) n_phase = PH_RST_REL;
                end
                PH_RST_REL: begin
                    if (t_end) n_phase = PH_RST_SAMP;
                end
                PH_RST_SAMP: begin
                    if (r_timer == '0) begin
                        n_high_cnt = r_high_cnt + CountW'(r_line);
                        n_samp_idx = r_samp_idx + CountW'(1);
                    end
                    if (t_end && n_samp_idx >= PresenceSamples) n_phase = PH_RST_HIGH;
                end
                PH_RST_HIGH: begin
                    // Wait for the line to come back high
                    if (r_line) begin
                        n_presence = (r_high_cnt <= i_cfg.presence_max);
                        n_phase    = PH_IDLE;
                        n_timer    = '0;
                        n_done     = 1'b1;
                    end
                end
                PH_WR_LOW: begin
                    if (t_end) n_phase = PH_WR_HOLD;
                end
                PH_WR_HOLD: begin
                    if (t_end) begin
                        n_shift = {1'b0, r_shift[ByteW-1:1]};
                        if (r_bit == '1) begin
                            n_bit   = '0;
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end else begin
                            n_bit   = r_bit + CountW'(1);
                            n_phase = PH_WR_LOW;
                        end
                    end
                end
                PH_RD_LOW: begin
                    if (t_end) n_phase = PH_RD_REL;
                end
                PH_RD_REL: begin
                    if (t_end) n_phase = PH_RD_REC;
                end
                PH_RD_REC: begin
                    // Sample on the first tick of recovery
                    if (r_timer == '0) n_shift = {r_line, r_shift[ByteW-1:1]};
                    if (t_end) begin
                        if (r_bit == '1) begin
                            n_bit       = '0;
                            n_last_read = n_shift;
                            n_phase     = PH_IDLE;
                            n_done      = 1'b1;
                        end else begin
                            n_bit   = r_bit + CountW'(1);
                            n_phase = PH_RD_LOW;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_timer = '0;
                end
            endcase
        end
    end

    // Line drive from the state after the update
    always_comb begin
        case (n_phase)
            PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: n_drive = 1'b1;
            PH_WR_HOLD:                       n_drive = !n_shift[0];
            default:                          n_drive = 1'b0;
        endcase
    end

    // Hold state, input beat and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_high_cnt  <= '0;
            r_samp_idx  <= '0;
            r_presence  <= 1'b0;
            r_last_read <= '0;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_phase     <= n_phase;
                r_timer     <= n_timer;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_high_cnt  <= n_high_cnt;
                r_samp_idx  <= n_samp_idx;
                r_presence  <= n_presence;
                r_last_read <= n_last_read;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_action <= i_cmd.action;
            r_data   <= i_cmd.data_byte;
            r_line   <= i_cmd.line_in;
        end
        if (fire) begin
            r_drive <= n_drive;
            r_busy  <= (n_phase != PH_IDLE);
            r_done  <= n_done;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.drive_low   = r_drive;
    assign o_res.busy_res    = r_busy;
    assign o_res.done_res    = r_done;
    assign o_res.presence_ok = r_presence;
    assign o_res.read_byte   = r_last_read;

endmodule

/* hdl/one_wire_bus_master_top.sv */
`timescale 1ns / 1ps
// 1-Wire bus master sequencer, stepped by one-microsecond tick beats.
// Command channel i_cmd: each beat carries action (tick, start reset, start
// write byte, start read byte), the byte to write and the sampled bus level.
// Result channel o_res: exactly one beat per command beat, in order, with the
// open-drain drive, busy, done, last presence result and last read byte.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write the timing
// registers; write them only while the block is idle.
// Each command beat passes through the input register, then the result
// register.
// Throughput: one beat per cycle while o_res is ready; the sequencer state
// is updated in the single logic stage between the two registers.
// Reset: synchronous, active low; the sequencer goes idle, presence and the
// read byte clear and the timing registers take their defaults.
// Stall: when o_res is not ready the result holds and the input register
// fills; i_cmd.ready drops only once both registers hold a beat.
// A start command that arrives while busy is dropped but still gets a beat.

`include "assert_macros.svh"

module one_wire_bus_master_top
    import owbm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    owbm_cmd_if.sink            i_cmd,
    owbm_res_if.source          o_res,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg cfg;

    owbm_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    owbm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (i_cmd),
        .o_res   (o_res)
    );

    // A finishing beat always leaves the sequencer idle
    `OWBM_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, o_res.valid && o_res.done_res, !o_res.busy_res, "done while still busy")
    // The line is only pulled low during an operation
    `OWBM_ASSERT_IMPLY(a_drive_busy, i_clk, i_rst_n, o_res.valid && o_res.drive_low, o_res.busy_res, "line driven while idle")
    // Back-pressure on commands only comes from a full result register
    `OWBM_ASSERT_IMPLY(a_ready_stall, i_clk, i_rst_n, !i_cmd.ready, o_res.valid, "command stalled with empty result register")

endmodule

/* sim/one_wire_bus_master_top_tb.sv */
`timescale 1ns / 1ps

module one_wire_bus_master_top_tb
    import owbm_pkg::*;
();

    // Sequencer phases as the checker tracks them
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_RST_REL,
        SEQ_RST_SAMP,
        SEQ_RST_HIGH,
        SEQ_WR_LOW,
        SEQ_WR_HOLD,
        SEQ_RD_LOW,
        SEQ_RD_REL,
        SEQ_RD_REC
    } t_seq;

    // One result beat
    typedef struct packed {
        logic             drive_low;
        logic             busy;
        logic             done;
        logic             presence_ok;
        logic [ByteW-1:0] read_byte;
    } t_bus_res;

    // Mirror of the sequencer plus the queue of result beats still owed
    class owbm_scoreboard;
        t_cfg             cfg;
        t_seq             seq;
        logic [TimerW-1:0] timer;
        logic [2:0]       bit_idx;
        logic [ByteW-1:0] shreg;
        logic [CountW-1:0] highs;
        logic [CountW-1:0] samples;
        logic             presence;
        logic [ByteW-1:0] last_read;
        t_bus_res         status_beats_due[$];
        int               errors;
        int               checked;
        int               n_present;
        int               n_absent;
        int               n_writes;
        int               n_reads;

        function new();
            cfg = '{reset_low: ResetLowDef, presence_delay: PresenceDelayDef,
                    presence_max: PresenceMaxDef, write_low: WriteLowDef,
                    write_hold: WriteHoldDef, read_low: ReadLowDef,
                    read_sample: ReadSampleDef, read_recover: ReadRecoverDef};
            seq = SEQ_IDLE;
            timer = '0;
            bit_idx = '0;
            shreg = '0;
            highs = '0;
            samples = '0;
            presence = 1'b0;
            last_read = '0;
            errors = 0;
            checked = 0;
            n_present = 0;
            n_absent = 0;
            n_writes = 0;
            n_reads = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CfgDataW-1:0] val);
            case (idx)
                CFG_RESET_LOW:      cfg.reset_low      = val;
                CFG_PRESENCE_DELAY: cfg.presence_delay = val[7:0];
                CFG_PRESENCE_MAX:   cfg.presence_max   = val[2:0];
                CFG_WRITE_LOW:      cfg.write_low      = val[7:0];
                CFG_WRITE_HOLD:     cfg.write_hold     = val[7:0];
                CFG_READ_LOW:       cfg.read_low       = val[7:0];
                CFG_READ_SAMPLE:    cfg.read_sample    = val[7:0];
                CFG_READ_RECOVER:   cfg.read_recover   = val[7:0];
                default: ;
            endcase
        endfunction

        // Count one tick in the current phase; a zero length acts as one tick
        function bit slot_done(logic [TimerW-1:0] dur);
            timer = timer + 1'b1;
            if (dur == '0 || timer >= dur) begin
                timer = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void enter_seq(t_seq nxt);
            seq = nxt;
            timer = '0;
        endfunction

        // Advance the sequencer by one accepted command beat and queue the
        // result it owes; return 0 when the beat had no effect
        function bit step_slot_sequencer(t_action act, logic [ByteW-1:0] data, logic line);
            t_bus_res r;
            bit       effective;
            logic     done;
            effective = 1'b1;
            done = 1'b0;
            if (act != ACT_TICK) begin
                if (seq == SEQ_IDLE) begin
                    if (act == ACT_RESET) begin
                        highs = '0;
                        samples = '0;
                        enter_seq(SEQ_RST_LOW);
                    end else begin
                        bit_idx = '0;
                        shreg = (act == ACT_WRITE) ? data : '0;
                        enter_seq(act == ACT_WRITE ? SEQ_WR_LOW : SEQ_RD_LOW);
                    end
                end else begin
                    effective = 1'b0;
                end
            end else begin
                case (seq)
                    SEQ_IDLE: effective = 1'b0;
                    SEQ_RST_LOW: if (slot_done(cfg.reset_low)) enter_seq(SEQ_RST_REL);
                    SEQ_RST_REL: if (slot_done(cfg.presence_delay)) enter_seq(SEQ_RST_SAMP);
                    SEQ_RST_SAMP: begin
                        // sample on the first tick of each spacing window
                        if (timer == '0) begin
                            highs = highs + CountW'(line);
                            samples = samples + 1'b1;
                        end
                        if (slot_done(SampleSpacing) && samples >= PresenceSamples)
                            enter_seq(SEQ_RST_HIGH);
                    end
                    SEQ_RST_HIGH: begin
                        // hold until the line is seen high again
                        if (line) begin
                            presence = (highs <= cfg.presence_max);
                            if (presence) n_present++;
                            else n_absent++;
                            enter_seq(SEQ_IDLE);
                            done = 1'b1;
                        end
                    end
                    SEQ_WR_LOW: if (slot_done(cfg.write_low)) enter_seq(SEQ_WR_HOLD);
                    SEQ_WR_HOLD: begin
                        if (slot_done(cfg.write_hold)) begin
                            shreg = shreg >> 1;
                            if (bit_idx == 3'd7) begin
                                bit_idx = '0;
                                n_writes++;
                                enter_seq(SEQ_IDLE);
                                done = 1'b1;
                            end else begin
                                bit_idx++;
                                enter_seq(SEQ_WR_LOW);
                            end
                        end
                    end
                    SEQ_RD_LOW: if (slot_done(cfg.read_low)) enter_seq(SEQ_RD_REL);
                    SEQ_RD_REL: if (slot_done(cfg.read_sample)) enter_seq(SEQ_RD_REC);
                    SEQ_RD_REC: begin
                        // shift the bus level in at the top, LSB arrives first
                        if (timer == '0) shreg = {line, shreg[ByteW-1:1]};
                        if (slot_done(cfg.read_recover)) begin
                            if (bit_idx == 3'd7) begin
                                bit_idx = '0;
                                last_read = shreg;
                                n_reads++;
                                enter_seq(SEQ_IDLE);
                                done = 1'b1;
                            end else begin
                                bit_idx++;
                                enter_seq(SEQ_RD_LOW);
                            end
                        end
                    end
                    default: enter_seq(SEQ_IDLE);
                endcase
            end

            if (seq == SEQ_RST_LOW || seq == SEQ_WR_LOW || seq == SEQ_RD_LOW)
                r.drive_low = 1'b1;
            else if (seq == SEQ_WR_HOLD)
                r.drive_low = ~shreg[0];
            else
                r.drive_low = 1'b0;
            r.busy = (seq != SEQ_IDLE);
            r.done = done;
            r.presence_ok = presence;
            r.read_byte = last_read;
            status_beats_due.push_back(r);
            return effective;
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            if (errors <= 40)
                $display("MISMATCH at result %0d: %s got %0d expected %0d",
                         checked, what, got, want);
        endtask

        // Compare one accepted result beat against the oldest one owed
        task check_result_beat(t_bus_res got);
            t_bus_res want;
            checked++;
            if (status_beats_due.size() == 0) begin
                report_mismatch("result beat with nothing owed", 1, 0);
            end else begin
                want = status_beats_due.pop_front();
                if (got.drive_low !== want.drive_low)
                    report_mismatch("drive_low", got.drive_low, want.drive_low);
                if (got.busy !== want.busy)
                    report_mismatch("busy_res", got.busy, want.busy);
                if (got.done !== want.done)
                    report_mismatch("done_res", got.done, want.done);
                if (got.presence_ok !== want.presence_ok)
                    report_mismatch("presence_ok", got.presence_ok, want.presence_ok);
                if (got.read_byte !== want.read_byte)
                    report_mismatch("read_byte", got.read_byte, want.read_byte);
            end
        endtask

        task check_leftovers();
            if (status_beats_due.size() != 0)
                report_mismatch("result beats never seen", status_beats_due.size(), 0);
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    owbm_cmd_if cmd_bus();
    owbm_res_if res_bus();

    owbm_scoreboard bus_seq;

    int   src_idle_pct;
    int   rcv_idle_pct;
    int   live_items;
    int   cfg_sets;
    logic rcv_hold;
    logic stall_req;

    localparam int HoldOffCycles = 300;

    one_wire_bus_master_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_bus),
        .o_res      (res_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive ready: random stalls, or a forced hold-off
    always @(posedge i_clk) begin
        res_bus.ready <= !rcv_hold && ($urandom_range(99) >= rcv_idle_pct);
    end

    // Check every accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready)
            bus_seq.check_result_beat({res_bus.drive_low, res_bus.busy_res, res_bus.done_res,
                                       res_bus.presence_ok, res_bus.read_byte});
    end

    // Hold off the receiver for a long stretch once asked
    initial begin
        rcv_hold <= 1'b0;
        do @(posedge i_clk); while (!stall_req);
        rcv_hold <= 1'b1;
        repeat (HoldOffCycles) @(posedge i_clk);
        rcv_hold <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one command beat, wait for it to be taken, then update the mirror
    task automatic send_cmd(t_action act, logic [ByteW-1:0] data, logic line);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.action    <= act;
        cmd_bus.data_byte <= data;
        cmd_bus.line_in   <= line;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        if (bus_seq.step_slot_sequencer(act, data, line)) live_items++;
    endtask

    // Tick until the sequencer is idle; now and then throw in a stray command
    task automatic finish_op(int hi_pct, int release_pct);
        logic ln;
        while (bus_seq.seq != SEQ_IDLE) begin
            if ($urandom_range(99) < 4) begin
                send_cmd(t_action'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
            end else begin
                if (bus_seq.seq == SEQ_RST_HIGH)
                    ln = ($urandom_range(99) < release_pct);
                else
                    ln = ($urandom_range(99) < hi_pct);
                send_cmd(ACT_TICK, 8'($urandom), ln);
            end
        end
    endtask

    task automatic run_op(t_action op, logic [ByteW-1:0] data, int hi_pct, int release_pct);
        send_cmd(op, data, 1'($urandom));
        finish_op(hi_pct, release_pct);
    endtask

    // Drop valid and wait until every owed result beat is back
    task automatic settle();
        cmd_bus.valid <= 1'b0;
        while (bus_seq.status_beats_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all timing registers, one per cycle
    task automatic apply_cfg(t_cfg c);
        logic [CfgDataW-1:0] vals [CfgNum];
        t_cfg_idx            idx;
        vals[CFG_RESET_LOW]      = c.reset_low;
        vals[CFG_PRESENCE_DELAY] = CfgDataW'(c.presence_delay);
        vals[CFG_PRESENCE_MAX]   = CfgDataW'(c.presence_max);
        vals[CFG_WRITE_LOW]      = CfgDataW'(c.write_low);
        vals[CFG_WRITE_HOLD]     = CfgDataW'(c.write_hold);
        vals[CFG_READ_LOW]       = CfgDataW'(c.read_low);
        vals[CFG_READ_SAMPLE]    = CfgDataW'(c.read_sample);
        vals[CFG_READ_RECOVER]   = CfgDataW'(c.read_recover);
        for (int i = 0; i < CfgNum; i++) begin
            idx = t_cfg_idx'(i);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= vals[idx];
            @(posedge i_clk);
            bus_seq.set_reg(idx, vals[idx]);
        end
        i_cfg_we <= 1'b0;
        cfg_sets++;
    endtask

    // Short timings keep operations quick; a few are stretched
    function automatic t_cfg pick_cfg();
        t_cfg c;
        c.reset_low      = 10'($urandom_range(0, 12));
        c.presence_delay = 8'($urandom_range(0, 8));
        c.presence_max   = 3'($urandom_range(0, 7));
        c.write_low      = 8'($urandom_range(0, 5));
        c.write_hold     = 8'($urandom_range(0, 5));
        c.read_low       = 8'($urandom_range(0, 5));
        c.read_sample    = 8'($urandom_range(0, 5));
        c.read_recover   = 8'($urandom_range(0, 5));
        if ($urandom_range(9) == 0) c.reset_low = 10'($urandom_range(13, 600));
        if ($urandom_range(9) == 0) c.write_hold = 8'($urandom_range(6, 60));
        if ($urandom_range(9) == 0) c.read_recover = 8'($urandom_range(6, 60));
        return c;
    endfunction

    // Sender busy/receiver lazy, then swapped, then both flat out
    function automatic void set_idle_profile(int n);
        if (n < 130) begin
            src_idle_pct = 25;
            rcv_idle_pct = 67;
        end else if (n < 260) begin
            src_idle_pct = 67;
            rcv_idle_pct = 25;
        end else begin
            src_idle_pct = 0;
            rcv_idle_pct = 0;
        end
    endfunction

    initial begin
        t_cfg phase_cfg;
        int   rand_base;
        int   n_ops;

        bus_seq = new();
        live_items = 0;
        cfg_sets = 0;
        i_rst_n           <= 1'b0;
        cmd_bus.valid     <= 1'b0;
        cmd_bus.action    <= ACT_TICK;
        cmd_bus.data_byte <= '0;
        cmd_bus.line_in   <= 1'b1;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_RESET_LOW;
        i_cfg_data        <= '0;
        stall_req         <= 1'b0;
        set_idle_profile(0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default timings: idle tick, then one write byte
        send_cmd(ACT_TICK, 8'h00, 1'b0);
        run_op(ACT_WRITE, 8'h5A, 50, 50);
        settle();

        // Zero timings act as one tick; strictest presence threshold
        phase_cfg = '0;
        apply_cfg(phase_cfg);
        run_op(ACT_RESET, 8'h00, 100, 100);
        run_op(ACT_RESET, 8'hFF, 0, 30);
        send_cmd(ACT_WRITE, 8'hC3, 1'b0);
        send_cmd(ACT_RESET, 8'h00, 1'b1);
        send_cmd(ACT_READ, 8'h3C, 1'b0);
        send_cmd(ACT_WRITE, 8'hFF, 1'b1);
        finish_op(50, 50);
        run_op(ACT_READ, 8'h00, 0, 50);
        run_op(ACT_READ, 8'h00, 50, 50);
        settle();

        // Random operations under random short timings
        rand_base = live_items;
        while (live_items - rand_base < 400) begin
            apply_cfg(pick_cfg());
            n_ops = $urandom_range(2, 6);
            for (int k = 0; k < n_ops; k++) begin
                set_idle_profile(live_items - rand_base);
                if (!stall_req && live_items - rand_base >= 100) stall_req <= 1'b1;
                if ($urandom_range(99) < 30)
                    repeat ($urandom_range(1, 3)) send_cmd(ACT_TICK, 8'($urandom), 1'($urandom));
                run_op(t_action'($urandom_range(1, 3)), 8'($urandom),
                       $urandom_range(4) * 25, $urandom_range(10, 70));
            end
            settle();
        end

        bus_seq.check_leftovers();
        $display("Checked %0d result beats over %0d timing settings and a %0d-cycle hold-off.",
                 bus_seq.checked, cfg_sets, HoldOffCycles);
        $display("Finished %0d resets (%0d present, %0d absent), %0d writes, %0d reads.",
                 bus_seq.n_present + bus_seq.n_absent, bus_seq.n_present, bus_seq.n_absent,
                 bus_seq.n_writes, bus_seq.n_reads);
        if (bus_seq.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
